// File: sv/imu_bias_calibrate_and_axis_remap_assert.svh
// assertion macros for the imu bias calibration and axis remap block
`ifndef IMU_BIAS_CALIBRATE_AND_AXIS_REMAP_ASSERT_SVH
`define IMU_BIAS_CALIBRATE_AND_AXIS_REMAP_ASSERT_SVH
`ifndef ASSERT_OFF
// check a property at every clock edge outside reset
`define IMUCAL_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("imucal assertion failed");
// check a property at every clock edge, reset included
`define IMUCAL_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("imucal assertion failed");
`else
`define IMUCAL_ASSERT(name, clk, rst, prop)
`define IMUCAL_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

// File: sv/imucal_pkg.sv
// shared types, constants and orientation tables of the imu calibration block
package imucal_pkg;

   localparam int RAW_W  = 16;
   localparam int OUT_W  = 20;
   localparam int BIAS_W = 17;
   localparam int AVG_W  = 16;
   localparam int SEL_W  = 2;
   localparam int ORI_W  = 3;
   localparam int AXES   = 3;
   localparam int LANES  = 6;

   localparam logic signed [BIAS_W-1:0] ONE_G = 17'sd16384;

   // item kinds
   localparam logic REQ_MEAS = 1'b0;
   localparam logic REQ_CAL  = 1'b1;
   localparam logic RES_MEAS = 1'b0;
   localparam logic RES_BIAS = 1'b1;

   // register indexes of the csr port
   localparam logic [1:0] CSR_ACCEL_RANGE = 2'd0;
   localparam logic [1:0] CSR_GYRO_RANGE  = 2'd1;
   localparam logic [1:0] CSR_ORIENT      = 2'd2;

   // per orientation: source axis of each output axis
   localparam logic [1:0] AXIS_SRC [0:7][0:2] = '{
      '{2'd0, 2'd1, 2'd2}, '{2'd1, 2'd0, 2'd2}, '{2'd0, 2'd1, 2'd2}, '{2'd1, 2'd0, 2'd2},
      '{2'd2, 2'd1, 2'd0}, '{2'd2, 2'd0, 2'd1}, '{2'd2, 2'd1, 2'd0}, '{2'd2, 2'd0, 2'd1}
   };

   // per orientation: negate flag of each output axis
   localparam logic AXIS_NEG [0:7][0:2] = '{
      '{1'b0, 1'b0, 1'b0}, '{1'b1, 1'b0, 1'b0}, '{1'b1, 1'b1, 1'b0}, '{1'b0, 1'b1, 1'b0},
      '{1'b1, 1'b1, 1'b1}, '{1'b1, 1'b0, 1'b1}, '{1'b1, 1'b0, 1'b0}, '{1'b1, 1'b1, 1'b0}
   };

   // per orientation: axis that carries gravity
   localparam logic [1:0] GRAVITY_AXIS [0:7] = '{
      2'd2, 2'd2, 2'd2, 2'd2, 2'd0, 2'd1, 2'd0, 2'd1
   };

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_EMIT
   } state_type;

   // per-cycle commands from the sequencer to every lane
   typedef struct packed {
      logic acc_en;   // add the raw sample to the running sum
      logic last;     // load the divider and clear the sum
      logic step;     // one divider iteration
   } lane_ctrl_type;

endpackage

// File: sv/imucal_lane.sv
// one axis lane: calibration sum, serial divider, bias and measurement correction
module imucal_lane import imucal_pkg::*; #(
   parameter int SUM_W = 23,
   parameter int CNT_W = 7
) (
   input  logic                     clock,
   input  logic                     reset,
   input  lane_ctrl_type            ctrl,
   input  logic signed [RAW_W-1:0]  raw,
   input  logic [SEL_W-1:0]         range_sel,
   input  logic [CNT_W-1:0]         divisor,
   input  logic                     bias_load,
   input  logic signed [BIAS_W-1:0] bias_in,
   output logic signed [AVG_W-1:0]  avg,
   output logic signed [OUT_W-1:0]  corr
);

   logic signed [SUM_W-1:0]  sum_ff, sum_in, sum_nxt;
   logic [SUM_W-1:0]         quo_ff, quo_in, sum_mag;
   logic [CNT_W-1:0]         rem_ff, rem_in;
   logic                     sign_ff, sign_in;
   logic signed [BIAS_W-1:0] bias_ff, bias_in_sel;
   logic [CNT_W:0]           shifted, diff;
   logic                     ge;
   logic [AVG_W-1:0]         q_low;
   logic signed [OUT_W-1:0]  scaled;

   // running sum and its magnitude for the divider
   always_comb begin
      sum_nxt = ctrl.acc_en ? sum_ff + {{(SUM_W-RAW_W){raw[RAW_W-1]}}, raw} : sum_ff;
      sum_mag = sum_nxt[SUM_W-1] ? SUM_W'(-sum_nxt) : SUM_W'(sum_nxt);
      sum_in  = ctrl.last ? '0 : sum_nxt;
   end

   // restoring divider, one quotient bit per step
   always_comb begin
      shifted = {rem_ff, quo_ff[SUM_W-1]};
      diff    = shifted - {1'b0, divisor};
      ge      = ~diff[CNT_W];
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      sign_in = sign_ff;
      if (ctrl.last) begin
         rem_in  = '0;
         quo_in  = sum_mag;
         sign_in = sum_nxt[SUM_W-1];
      end else if (ctrl.step) begin
         rem_in = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
         quo_in = {quo_ff[SUM_W-2:0], ge};
      end
   end

   // signed average, truncated toward zero
   always_comb begin
      q_low = quo_ff[AVG_W-1:0];
      if (divisor == '0) begin
         avg = '0;
      end else begin
         avg = sign_ff ? AVG_W'(-q_low) : AVG_W'(q_low);
      end
   end

   // measurement: range shift then bias removal
   always_comb begin
      scaled      = {{(OUT_W-RAW_W){raw[RAW_W-1]}}, raw} <<< range_sel;
      corr        = scaled - {{(OUT_W-BIAS_W){bias_ff[BIAS_W-1]}}, bias_ff};
      bias_in_sel = bias_load ? bias_in : bias_ff;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         bias_ff <= '0;
      end else begin
         sum_ff  <= sum_in;
         bias_ff <= bias_in_sel;
      end
   end

   // divider working registers
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      sign_ff <= sign_in;
   end

endmodule

// File: sv/imucal_merge.sv
// merging stage: axis remap of corrected samples and gravity removal from biases
module imucal_merge import imucal_pkg::*; (
   input  logic [ORI_W-1:0]         orient,
   input  logic                     sel_bias,
   input  logic signed [OUT_W-1:0]  acc_corr [AXES],
   input  logic signed [OUT_W-1:0]  gyr_corr [AXES],
   input  logic signed [AVG_W-1:0]  acc_avg  [AXES],
   input  logic signed [AVG_W-1:0]  gyr_avg  [AXES],
   output logic signed [BIAS_W-1:0] acc_bias [AXES],
   output logic signed [BIAS_W-1:0] gyr_bias [AXES],
   output logic signed [OUT_W-1:0]  acc_res  [AXES],
   output logic signed [OUT_W-1:0]  gyr_res  [AXES]
);

   logic [1:0]              grav;
   logic [1:0]              src  [AXES];
   logic                    neg  [AXES];
   logic signed [OUT_W-1:0] acc_sel [AXES];
   logic signed [OUT_W-1:0] gyr_sel [AXES];

   // new biases: on the gravity axis one g is subtracted from a positive average, else added
   always_comb begin
      grav = GRAVITY_AXIS[orient];
      for (int i = 0; i < AXES; i++) begin
         acc_bias[i] = {acc_avg[i][AVG_W-1], acc_avg[i]};
         gyr_bias[i] = {gyr_avg[i][AVG_W-1], gyr_avg[i]};
         if (2'(i) == grav) begin
            if (acc_bias[i] > 0) begin
               acc_bias[i] = acc_bias[i] - ONE_G;
            end else begin
               acc_bias[i] = acc_bias[i] + ONE_G;
            end
         end
      end
   end

   // permute and negate, or pass the biases in sensor order
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         src[i]     = AXIS_SRC[orient][i];
         neg[i]     = AXIS_NEG[orient][i];
         acc_sel[i] = acc_corr[src[i]];
         gyr_sel[i] = gyr_corr[src[i]];
         if (sel_bias) begin
            acc_res[i] = {{(OUT_W-BIAS_W){acc_bias[i][BIAS_W-1]}}, acc_bias[i]};
            gyr_res[i] = {{(OUT_W-BIAS_W){gyr_bias[i][BIAS_W-1]}}, gyr_bias[i]};
         end else begin
            acc_res[i] = neg[i] ? -acc_sel[i] : acc_sel[i];
            gyr_res[i] = neg[i] ? -gyr_sel[i] : gyr_sel[i];
         end
      end
   end

endmodule

// File: sv/imu_bias_calibrate_and_axis_remap.sv
// imu bias calibration and axis remap, top level
// measurement item: result registered at the accepting edge, one item per cycle while req_stall is low
// calibration item that is not last: accumulated into the running sums, no result
// last calibration item: the serial dividers run in the divide state, then the biases are formed
//   and the result registered in the emit state; the six lane dividers run together
// synchronous reset restores the range and orientation defaults and clears sums, count, biases
`include "imu_bias_calibrate_and_axis_remap_assert.svh"
module imu_bias_calibrate_and_axis_remap import imucal_pkg::*; #(
   parameter int CAL_SAMPLES_MAX = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   // configuration
   input  logic                    csr_we,
   input  logic [1:0]              csr_index,
   input  logic [ORI_W-1:0]        csr_wdata,
   // request channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_type,
   input  logic                    req_cal_last,
   input  logic signed [RAW_W-1:0] req_accel_x_raw,
   input  logic signed [RAW_W-1:0] req_accel_y_raw,
   input  logic signed [RAW_W-1:0] req_accel_z_raw,
   input  logic signed [RAW_W-1:0] req_gyro_x_raw,
   input  logic signed [RAW_W-1:0] req_gyro_y_raw,
   input  logic signed [RAW_W-1:0] req_gyro_z_raw,
   // response channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_result_kind,
   output logic signed [OUT_W-1:0] rsp_accel_x_out,
   output logic signed [OUT_W-1:0] rsp_accel_y_out,
   output logic signed [OUT_W-1:0] rsp_accel_z_out,
   output logic signed [OUT_W-1:0] rsp_gyro_x_out,
   output logic signed [OUT_W-1:0] rsp_gyro_y_out,
   output logic signed [OUT_W-1:0] rsp_gyro_z_out
);

   localparam int CNT_W  = $clog2(CAL_SAMPLES_MAX + 1);
   localparam int SUM_W  = RAW_W + 1 + $clog2(CAL_SAMPLES_MAX);
   localparam int STEP_W = $clog2(SUM_W);

   state_type               state_ff, state_in;
   logic [SEL_W-1:0]        acc_sel_ff, acc_sel_in, gyr_sel_ff, gyr_sel_in;
   logic [ORI_W-1:0]        orient_ff, orient_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in, div_ff, div_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    kind_ff, kind_in;
   logic signed [OUT_W-1:0] out_ff [LANES];
   logic signed [OUT_W-1:0] out_in [LANES];

   lane_ctrl_type           ctrl;
   logic                    accept, out_free, cnt_full, load_meas, load_bias, sel_bias;
   logic signed [RAW_W-1:0] raw      [LANES];
   logic [SEL_W-1:0]        lane_sel [LANES];
   logic signed [BIAS_W-1:0] lane_bias [LANES];
   logic signed [AVG_W-1:0] lane_avg  [LANES];
   logic signed [OUT_W-1:0] lane_corr [LANES];
   logic signed [OUT_W-1:0] acc_corr [AXES];
   logic signed [OUT_W-1:0] gyr_corr [AXES];
   logic signed [AVG_W-1:0] acc_avg  [AXES];
   logic signed [AVG_W-1:0] gyr_avg  [AXES];
   logic signed [BIAS_W-1:0] acc_bias [AXES];
   logic signed [BIAS_W-1:0] gyr_bias [AXES];
   logic signed [OUT_W-1:0] acc_res  [AXES];
   logic signed [OUT_W-1:0] gyr_res  [AXES];

   // configuration registers
   always_comb begin
      acc_sel_in = acc_sel_ff;
      gyr_sel_in = gyr_sel_ff;
      orient_in  = orient_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ACCEL_RANGE: acc_sel_in = csr_wdata[SEL_W-1:0];
            CSR_GYRO_RANGE:  gyr_sel_in = csr_wdata[SEL_W-1:0];
            CSR_ORIENT:      orient_in  = csr_wdata;
            default:         ;
         endcase
      end
   end

   // lane inputs
   always_comb begin
      raw[0] = req_accel_x_raw;
      raw[1] = req_accel_y_raw;
      raw[2] = req_accel_z_raw;
      raw[3] = req_gyro_x_raw;
      raw[4] = req_gyro_y_raw;
      raw[5] = req_gyro_z_raw;
      for (int i = 0; i < AXES; i++) begin
         lane_sel[i]        = acc_sel_ff;
         lane_sel[i + AXES] = gyr_sel_ff;
         lane_bias[i]        = acc_bias[i];
         lane_bias[i + AXES] = gyr_bias[i];
         acc_corr[i] = lane_corr[i];
         gyr_corr[i] = lane_corr[i + AXES];
         acc_avg[i]  = lane_avg[i];
         gyr_avg[i]  = lane_avg[i + AXES];
      end
   end

   // sequencer: accept, accumulate, divide, emit
   always_comb begin
      out_free    = ~rsp_valid_ff | ~rsp_stall;
      req_stall   = ~((state_ff == ST_IDLE) & out_free);
      accept      = req_valid & ~req_stall;
      cnt_full    = (cnt_ff == CNT_W'(CAL_SAMPLES_MAX));
      ctrl.acc_en = accept & (req_type == REQ_CAL) & ~cnt_full;
      ctrl.last   = accept & (req_type == REQ_CAL) & req_cal_last;
      ctrl.step   = 1'b0;
      load_meas   = accept & (req_type == REQ_MEAS);
      load_bias   = 1'b0;
      sel_bias    = 1'b0;
      state_in    = state_ff;
      step_in     = step_ff;
      div_in      = div_ff;
      cnt_in      = ctrl.acc_en ? cnt_ff + 1'b1 : cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (ctrl.last) begin
               div_in   = cnt_in;
               cnt_in   = '0;
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            ctrl.step = 1'b1;
            step_in   = step_ff + 1'b1;
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            sel_bias = 1'b1;
            if (out_free) begin
               load_bias = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      kind_in      = kind_ff;
      for (int i = 0; i < AXES; i++) begin
         out_in[i]        = out_ff[i];
         out_in[i + AXES] = out_ff[i + AXES];
      end
      if (load_meas | load_bias) begin
         rsp_valid_in = 1'b1;
         kind_in      = load_bias ? RES_BIAS : RES_MEAS;
         for (int i = 0; i < AXES; i++) begin
            out_in[i]        = acc_res[i];
            out_in[i + AXES] = gyr_res[i];
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_sel_ff   <= 2'd3;
         gyr_sel_ff   <= 2'd3;
         orient_ff    <= '0;
         cnt_ff       <= '0;
         div_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_sel_ff   <= acc_sel_in;
         gyr_sel_ff   <= gyr_sel_in;
         orient_ff    <= orient_in;
         cnt_ff       <= cnt_in;
         div_ff       <= div_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result fields
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      for (int i = 0; i < LANES; i++) begin
         out_ff[i] <= out_in[i];
      end
   end

   // six axis lanes
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      imucal_lane #(
         .SUM_W (SUM_W),
         .CNT_W (CNT_W)
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .raw       (raw[g]),
         .range_sel (lane_sel[g]),
         .divisor   (div_ff),
         .bias_load (load_bias),
         .bias_in   (lane_bias[g]),
         .avg       (lane_avg[g]),
         .corr      (lane_corr[g])
      );
   end

   imucal_merge u_merge (
      .orient   (orient_ff),
      .sel_bias (sel_bias),
      .acc_corr (acc_corr),
      .gyr_corr (gyr_corr),
      .acc_avg  (acc_avg),
      .gyr_avg  (gyr_avg),
      .acc_bias (acc_bias),
      .gyr_bias (gyr_bias),
      .acc_res  (acc_res),
      .gyr_res  (gyr_res)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_accel_x_out = out_ff[0];
   assign rsp_accel_y_out = out_ff[1];
   assign rsp_accel_z_out = out_ff[2];
   assign rsp_gyro_x_out  = out_ff[3];
   assign rsp_gyro_y_out  = out_ff[4];
   assign rsp_gyro_z_out  = out_ff[5];

   // no item taken while the divider or bias emission is busy
   `IMUCAL_ASSERT(a_busy_stalls, clock, reset, (state_ff != ST_IDLE) |-> req_stall)
   // a last calibration item starts the divider
   `IMUCAL_ASSERT(a_last_starts_div, clock, reset, ctrl.last |=> (state_ff == ST_DIV))
   // bias emission puts a bias result in the output register
   `IMUCAL_ASSERT(a_emit_loads, clock, reset,
      (state_ff == ST_EMIT && out_free) |=> (rsp_valid_ff && kind_ff == RES_BIAS))
   // the sample count never passes its limit
   `IMUCAL_ASSERT(a_cnt_bound, clock, reset, cnt_ff <= CNT_W'(CAL_SAMPLES_MAX))

endmodule

// File: sim/tb.sv
// self-checking testbench for the imu bias calibration and axis remap block
`timescale 1ns / 1ps

module tb;
   import imucal_pkg::*;

   localparam int CAL_LIMIT   = 64;
   localparam int SETTLE      = 40;
   localparam int N_DIRECTED  = 20;
   localparam int N_PHASES    = 12;
   localparam int PHASE_ITEMS = 42;

   // one input item, with an optional hand-typed result
   typedef struct packed {
      logic                        typ;
      logic                        last;
      logic [0:5][RAW_W-1:0]       raw;
      logic                        chk;
      logic [0:5][OUT_W-1:0]       want;
   } stim_row_type;

   // one result item: accel x,y,z then gyro x,y,z
   typedef struct packed {
      logic                        kind;
      logic [0:5][OUT_W-1:0]       val;
   } imu_result_type;

   logic                    clock;
   logic                    reset;
   logic                    csr_we;
   logic [1:0]              csr_index;
   logic [ORI_W-1:0]        csr_wdata;
   logic                    req_valid;
   logic                    req_stall;
   logic                    req_type;
   logic                    req_cal_last;
   logic signed [RAW_W-1:0] req_accel_x_raw;
   logic signed [RAW_W-1:0] req_accel_y_raw;
   logic signed [RAW_W-1:0] req_accel_z_raw;
   logic signed [RAW_W-1:0] req_gyro_x_raw;
   logic signed [RAW_W-1:0] req_gyro_y_raw;
   logic signed [RAW_W-1:0] req_gyro_z_raw;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic                    rsp_result_kind;
   logic signed [OUT_W-1:0] rsp_accel_x_out;
   logic signed [OUT_W-1:0] rsp_accel_y_out;
   logic signed [OUT_W-1:0] rsp_accel_z_out;
   logic signed [OUT_W-1:0] rsp_gyro_x_out;
   logic signed [OUT_W-1:0] rsp_gyro_y_out;
   logic signed [OUT_W-1:0] rsp_gyro_z_out;

   bit             steady = 1'b0;
   int             fail_count = 0;
   imu_result_type awaited_results [$];
   string          field_name [6] = '{"accel_x", "accel_y", "accel_z",
                                      "gyro_x", "gyro_y", "gyro_z"};

   // predictor copy of registers and calibration state
   int     acc_shift;
   int     gyr_shift;
   int     mount;
   int     acc_bias [3];
   int     gyr_bias [3];
   longint cal_sum [6];
   int     cal_cnt;

   imu_bias_calibrate_and_axis_remap #(
      .CAL_SAMPLES_MAX(CAL_LIMIT)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_cal_last    (req_cal_last),
      .req_accel_x_raw (req_accel_x_raw),
      .req_accel_y_raw (req_accel_y_raw),
      .req_accel_z_raw (req_accel_z_raw),
      .req_gyro_x_raw  (req_gyro_x_raw),
      .req_gyro_y_raw  (req_gyro_y_raw),
      .req_gyro_z_raw  (req_gyro_z_raw),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_accel_x_out (rsp_accel_x_out),
      .rsp_accel_y_out (rsp_accel_y_out),
      .rsp_accel_z_out (rsp_accel_z_out),
      .rsp_gyro_x_out  (rsp_gyro_x_out),
      .rsp_gyro_y_out  (rsp_gyro_y_out),
      .rsp_gyro_z_out  (rsp_gyro_z_out)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   initial begin
      #4_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // receiver stalls at random outside the steady stretch
   always @(posedge clock) begin
      rsp_stall <= (reset || steady) ? 1'b0 : ($urandom_range(99) < 14);
   end

   // compare each accepted result with the oldest prediction
   always @(posedge clock) begin : result_check
      imu_result_type want;
      imu_result_type got;
      int i;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind = rsp_result_kind;
         got.val = {rsp_accel_x_out, rsp_accel_y_out, rsp_accel_z_out,
                    rsp_gyro_x_out, rsp_gyro_y_out, rsp_gyro_z_out};
         if (awaited_results.size() == 0) begin
            $display("%0t unexpected item: kind %0d", $time, got.kind);
            fail_count++;
         end else begin
            want = awaited_results.pop_front();
            if (want.kind !== got.kind) begin
               $display("%0t result_kind: expected %0d, actual %0d",
                        $time, want.kind, got.kind);
               fail_count++;
            end
            for (i = 0; i < 6; i++) begin
               if (want.val[i] !== got.val[i]) begin
                  $display("%0t %s: expected %0d, actual %0d", $time, field_name[i],
                           $signed(want.val[i]), $signed(got.val[i]));
                  fail_count++;
               end
            end
         end
      end
   end

   function automatic stim_row_type item_row(input logic typ, input logic last,
                                             input int ax, input int ay, input int az,
                                             input int gx, input int gy, input int gz);
      stim_row_type r;
      r = '0;
      r.typ = typ;
      r.last = last;
      r.raw = {RAW_W'(ax), RAW_W'(ay), RAW_W'(az), RAW_W'(gx), RAW_W'(gy), RAW_W'(gz)};
      return r;
   endfunction

   function automatic stim_row_type with_result(input stim_row_type r,
                                                input int ax, input int ay, input int az,
                                                input int gx, input int gy, input int gz);
      stim_row_type t;
      t = r;
      t.chk = 1'b1;
      t.want = {OUT_W'(ax), OUT_W'(ay), OUT_W'(az), OUT_W'(gx), OUT_W'(gy), OUT_W'(gz)};
      return t;
   endfunction

   // full-range sample with the extremes weighted up
   function automatic int rand_raw();
      case ($urandom_range(7))
         0: return 32767;
         1: return -32768;
         2: return $urandom_range(1) ? 0 : -1;
         default: return int'($urandom_range(65535)) - 32768;
      endcase
   endfunction

   function automatic int noise();
      return int'($urandom_range(400)) - 200;
   endfunction

   // calibration sample: mostly resting sensor with gravity on the mounted axis
   function automatic stim_row_type cal_sample(input logic last);
      int v [6];
      int i;
      if ($urandom_range(3) == 0) begin
         for (i = 0; i < 6; i++) v[i] = rand_raw();
      end else begin
         for (i = 0; i < 6; i++) v[i] = noise();
         v[GRAVITY_AXIS[mount]] += $urandom_range(1) ? 16384 : -16384;
      end
      return item_row(REQ_CAL, last, v[0], v[1], v[2], v[3], v[4], v[5]);
   endfunction

   // bias calibration and axis remap, one item at a time
   function automatic bit predict_imu(input stim_row_type r, output imu_result_type res);
      int raw [6];
      int acc [3];
      int gyr [3];
      int i;
      int src;
      int grav;
      res = '0;
      for (i = 0; i < 6; i++) raw[i] = int'($signed(r.raw[i]));
      if (r.typ == REQ_CAL) begin
         // accumulate until the sample limit is reached
         if (cal_cnt < CAL_LIMIT) begin
            for (i = 0; i < 6; i++) cal_sum[i] += raw[i];
            cal_cnt++;
         end
         if (!r.last) return 1'b0;
         // averages truncate toward zero, one g taken off a positive gravity axis, else added
         for (i = 0; i < 3; i++) begin
            acc[i] = int'(cal_sum[i] / cal_cnt);
            gyr_bias[i] = int'(cal_sum[3 + i] / cal_cnt);
         end
         grav = GRAVITY_AXIS[mount];
         if (acc[grav] > 0) acc[grav] -= int'(ONE_G);
         else acc[grav] += int'(ONE_G);
         for (i = 0; i < 3; i++) acc_bias[i] = acc[i];
         for (i = 0; i < 6; i++) cal_sum[i] = 0;
         cal_cnt = 0;
         res.kind = RES_BIAS;
         for (i = 0; i < 3; i++) begin
            res.val[i] = OUT_W'(acc_bias[i]);
            res.val[3 + i] = OUT_W'(gyr_bias[i]);
         end
         return 1'b1;
      end
      // scale, remove bias, then permute and negate
      for (i = 0; i < 3; i++) begin
         acc[i] = raw[i] * (1 << acc_shift) - acc_bias[i];
         gyr[i] = raw[3 + i] * (1 << gyr_shift) - gyr_bias[i];
      end
      res.kind = RES_MEAS;
      for (i = 0; i < 3; i++) begin
         src = AXIS_SRC[mount][i];
         res.val[i] = OUT_W'(AXIS_NEG[mount][i] ? -acc[src] : acc[src]);
         res.val[3 + i] = OUT_W'(AXIS_NEG[mount][i] ? -gyr[src] : gyr[src]);
      end
      return 1'b1;
   endfunction

   // drive one item, wait for it to be taken, then maybe idle
   task automatic put_item(input stim_row_type r);
      imu_result_type res;
      req_valid <= 1'b1;
      req_type <= r.typ;
      req_cal_last <= r.last;
      req_accel_x_raw <= r.raw[0];
      req_accel_y_raw <= r.raw[1];
      req_accel_z_raw <= r.raw[2];
      req_gyro_x_raw <= r.raw[3];
      req_gyro_y_raw <= r.raw[4];
      req_gyro_z_raw <= r.raw[5];
      do @(posedge clock); while (req_stall);
      if (predict_imu(r, res)) begin
         if (r.chk) res.val = r.want;
         awaited_results.push_back(res);
      end
      if (!steady && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // stop sending and let every pending result drain
   task automatic drain();
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input int val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= ORI_W'(val);
      @(posedge clock);
      case (idx)
         CSR_ACCEL_RANGE: acc_shift = val;
         CSR_GYRO_RANGE: gyr_shift = val;
         CSR_ORIENT: mount = val;
         default: ;
      endcase
   endtask

   initial begin : stimulus
      stim_row_type directed [N_DIRECTED];
      stim_row_type r;
      int k;
      int j;
      int n;
      int len;
      int pick;
      bit broken;
      bit paused;

      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_ACCEL_RANGE;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_type = REQ_MEAS;
      req_cal_last = 1'b0;
      req_accel_x_raw = '0;
      req_accel_y_raw = '0;
      req_accel_z_raw = '0;
      req_gyro_x_raw = '0;
      req_gyro_y_raw = '0;
      req_gyro_z_raw = '0;

      // state after reset
      acc_shift = 3;
      gyr_shift = 3;
      mount = 0;
      for (k = 0; k < 3; k++) begin
         acc_bias[k] = 0;
         gyr_bias[k] = 0;
      end
      for (k = 0; k < 6; k++) cal_sum[k] = 0;
      cal_cnt = 0;

      // directed items at reset settings: 16 g, 2000 dps, orientation 0
      directed = '{
         with_result(item_row(REQ_MEAS, 1'b0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0, 0),
         with_result(item_row(REQ_MEAS, 1'b0, 32767, 32767, 32767, 32767, 32767, 32767),
                     262136, 262136, 262136, 262136, 262136, 262136),
         with_result(item_row(REQ_MEAS, 1'b0, -32768, -32768, -32768, -32768, -32768,
                              -32768),
                     -262144, -262144, -262144, -262144, -262144, -262144),
         item_row(REQ_MEAS, 1'b0, 21845, -21846, 21845, -21846, 21845, -21846),
         item_row(REQ_MEAS, 1'b0, -21846, 21845, -21846, 21845, -21846, 21845),
         // last flag on a measurement is ignored
         item_row(REQ_MEAS, 1'b1, 1234, -5678, 16384, -7, 99, -1),
         // two-sample calibration, z above zero loses one g
         item_row(REQ_CAL, 1'b0, 200, -200, 16500, 10, -10, 3),
         with_result(item_row(REQ_CAL, 1'b1, 100, -100, 16300, 20, -20, -3),
                     150, -150, 16, 15, -15, 0),
         with_result(item_row(REQ_MEAS, 1'b0, 0, 0, 0, 0, 0, 0), -150, 150, -16, -15, 15, 0),
         // zero average gains one g
         with_result(item_row(REQ_CAL, 1'b1, 0, 0, 0, 0, 0, 0), 0, 0, 16384, 0, 0, 0),
         with_result(item_row(REQ_CAL, 1'b1, 32767, 0, -16384, -32768, 0, 0),
                     32767, 0, 0, -32768, 0, 0),
         item_row(REQ_MEAS, 1'b0, -32768, 32767, -32768, 32767, -32768, 32767),
         with_result(item_row(REQ_CAL, 1'b1, -32768, 0, -32768, 0, 0, 0),
                     -32768, 0, -16384, 0, 0, 0),
         item_row(REQ_MEAS, 1'b0, 32767, -32768, 32767, -32768, 32767, -32768),
         with_result(item_row(REQ_CAL, 1'b1, 0, 0, 1, 32767, 32767, 32767),
                     0, 0, -16383, 32767, 32767, 32767),
         item_row(REQ_MEAS, 1'b0, 32767, 32767, 32767, 32767, 32767, 32767),
         // three samples: averages truncate toward zero
         item_row(REQ_CAL, 1'b0, -1, 1, 16384, -5, 0, 0),
         item_row(REQ_CAL, 1'b0, -1, 1, 16384, -5, 0, 0),
         with_result(item_row(REQ_CAL, 1'b1, 0, 0, 16384, -4, 0, 0), 0, 0, 0, -4, 0, 0),
         item_row(REQ_MEAS, 1'b0, 0, 0, 0, 0, 0, 0)
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < N_DIRECTED; k++) put_item(directed[k]);
      drain();

      // random phases, each under its own range and orientation setting
      for (k = 0; k < N_PHASES; k++) begin
         if (k == 0) begin
            write_csr(CSR_ACCEL_RANGE, 0);
            write_csr(CSR_GYRO_RANGE, 0);
            write_csr(CSR_ORIENT, 0);
         end else if (k == 1) begin
            write_csr(CSR_ACCEL_RANGE, 3);
            write_csr(CSR_GYRO_RANGE, 3);
            write_csr(CSR_ORIENT, 7);
         end else begin
            write_csr(CSR_ACCEL_RANGE, $urandom_range(3));
            write_csr(CSR_GYRO_RANGE, $urandom_range(3));
            write_csr(CSR_ORIENT, k % 8);
         end
         csr_we <= 1'b0;
         steady = (k == 4);
         paused = 1'b0;
         n = 0;
         while (n < PHASE_ITEMS) begin
            // mid-phase hold-off until every result is back
            if (k == 6 && !paused && n >= PHASE_ITEMS / 2) begin
               paused = 1'b1;
               drain();
            end
            pick = $urandom_range(99);
            if (pick < 70) begin
               r = item_row(REQ_MEAS, $urandom_range(7) == 0, rand_raw(), rand_raw(),
                            rand_raw(), rand_raw(), rand_raw(), rand_raw());
               put_item(r);
               n++;
            end else begin
               // short calibration runs, sometimes cut off, rarely past the limit
               len = (pick < 97) ? $urandom_range(1, 6) : $urandom_range(60, 80);
               broken = ($urandom_range(9) == 0);
               for (j = 0; j < len; j++) begin
                  put_item(cal_sample((j == len - 1) && !broken));
                  n++;
               end
            end
         end
         drain();
      end
      steady = 1'b0;

      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+sv
sv/imucal_pkg.sv
sv/imucal_lane.sv
sv/imucal_merge.sv
sv/imu_bias_calibrate_and_axis_remap.sv
sim/tb.sv
